[design/area_weighted_box_average_assert.svh]
// Assertion macros for the box average block
`ifndef AREA_WEIGHTED_BOX_AVERAGE_ASSERT_SVH
`define AREA_WEIGHTED_BOX_AVERAGE_ASSERT_SVH
`define AWBA_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define AWBA_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

[design/awba_pkg.sv]
// Package: constants and types for the box average block
`timescale 1ns / 1ps
`default_nettype none
package awba_pkg;
	localparam int MAX_WIDTH = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int FRAC_BITS = 8;
	localparam int XB = $clog2(MAX_WIDTH);
	localparam int YB = $clog2(MAX_HEIGHT);
	localparam int AB = XB + YB;
	localparam int CB = 15;
	localparam logic [7:0] BLACK = 8'd0;
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_QUERY = 1'b1;
	localparam logic CFG_WIDTH = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;
	// coverage of one pixel along one axis is at most 2^FRAC_BITS
	localparam int WB = FRAC_BITS + 1;
	// area up to (64*256)^2 = 2^28
	localparam int ARB = 2 * (CB - 1) + 1;
	// sum of weights*255 fits in ARB + 8
	localparam int SB = ARB + 8;
	typedef logic [CB-1:0] coord_t;
endpackage
`default_nettype wire

[design/awba_div.sv]
// Restoring divider: one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module awba_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [awba_pkg::SB-1:0]   num,
	input  wire logic [awba_pkg::ARB-1:0]  den,
	output logic                           done,
	output logic [7:0]                     quo
);
	import awba_pkg::*;
	localparam int CNTB = $clog2(SB + 1);
	logic [SB-1:0] q_q;
	logic [ARB:0] r_q;
	logic [ARB-1:0] d_q;
	logic [CNTB-1:0] cnt_q;
	logic busy_q;
	logic [ARB+1:0] trial;
	assign trial = {r_q, q_q[SB-1]} - {2'b0, d_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNTB'(SB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTB'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (!trial[ARB+1]) begin
				r_q <= trial[ARB:0];
				q_q <= {q_q[SB-2:0], 1'b1};
			end else begin
				r_q <= {r_q[ARB-1:0], q_q[SB-1]};
				q_q <= {q_q[SB-2:0], 1'b0};
			end
		end
	end
	assign quo = (|q_q[SB-1:8]) ? 8'hFF : q_q[7:0];
endmodule
`default_nettype wire

[design/area_weighted_box_average.sv]
// Top level: pixel store, pixel walk sequencer and shared divider
//  channel | dir | handshake
//  in      | in  | in_valid / in_ready
//  out     | out | out_valid / out_ready
//  cfg     | in  | cfg_we, cfg_index, cfg_data
// A load writes the pixel store when it is accepted. A query with a bad width or height answers the next cycle.
// Other queries pass clip and area, walk each covered pixel through memory read,
// multiply and accumulate, run the divider once per channel, then output.
// The pixel walk and the 37-step divider take most of a query's time.
// Reset clears control state and output flags and sets the image size to 64 x 64;
// pixel contents and datapath registers are not reset. The result waits in an output register while out_ready is low.
`timescale 1ns / 1ps
`default_nettype none
module area_weighted_box_average (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  kind,
	input  wire logic [5:0]            pixel_x,
	input  wire logic [5:0]            pixel_y,
	input  wire logic [23:0]           pixel_color,
	input  wire logic signed [14:0]    rect_x,
	input  wire logic signed [14:0]    rect_y,
	input  wire logic signed [14:0]    rect_w,
	input  wire logic signed [14:0]    rect_h,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 avg_red,
	output logic [7:0]                 avg_green,
	output logic [7:0]                 avg_blue,
	output logic                       empty_area,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [6:0]            cfg_data
);
	import awba_pkg::*;
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CLIP = 4'd1;
	localparam logic [3:0] ST_AREA = 4'd2;
	localparam logic [3:0] ST_RD = 4'd3;
	localparam logic [3:0] ST_MUL = 4'd4;
	localparam logic [3:0] ST_ACC = 4'd5;
	localparam logic [3:0] ST_DIVS = 4'd6;
	localparam logic [3:0] ST_DIVW = 4'd7;
	localparam logic [3:0] ST_OUT = 4'd8;
	localparam int PB = CB + 2;
	localparam int PRB = 2 * WB + 8;

	logic [23:0] mem [MAX_WIDTH*MAX_HEIGHT];
	logic [23:0] rd_q;
	logic [6:0] imgw_q, imgh_q;
	logic [3:0] st_q;
	logic signed [PB-1:0] x0_q, y0_q, x1_q, y1_q;
	logic [XB-1:0] px_q, pxs_q;
	logic [YB-1:0] py_q;
	logic [WB-1:0] wx_q, wy_q;
	logic [ARB-1:0] area_q;
	logic [2*WB-1:0] wt_q;
	logic [SB-1:0] sum_q [3];
	logic [1:0] ch_q;
	logic [7:0] res_q [3];
	logic div_start, div_done;
	logic [7:0] div_quo;
	logic [SB-1:0] div_num;

	logic [7:0] w_eff, h_eff;
	logic signed [PB-1:0] rxe, rye, xe, ye, wlim, hlim;
	logic signed [PB-1:0] pxl, pxh, pyl, pyh;
	logic [PB-1:0] ax, ay;

	always_comb begin
		w_eff = (imgw_q > 7'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : {1'b0, imgw_q};
		h_eff = (imgh_q > 7'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : {1'b0, imgh_q};
		wlim = PB'(signed'({1'b0, w_eff, {FRAC_BITS{1'b0}}}));
		hlim = PB'(signed'({1'b0, h_eff, {FRAC_BITS{1'b0}}}));
		rxe = PB'(x0_q);
		rye = PB'(y0_q);
		xe = x1_q;
		ye = y1_q;
		pxl = PB'(signed'({1'b0, px_q, {FRAC_BITS{1'b0}}}));
		pxh = pxl + PB'(signed'(1 << FRAC_BITS));
		pyl = PB'(signed'({1'b0, py_q, {FRAC_BITS{1'b0}}}));
		pyh = pyl + PB'(signed'(1 << FRAC_BITS));
		ax = PB'(x1_q - x0_q);
		ay = PB'(y1_q - y0_q);
	end

	assign in_ready = (st_q == ST_IDLE) && !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			imgw_q <= 7'd64;
			imgh_q <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH: imgw_q <= cfg_data;
				CFG_HEIGHT: imgh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && kind == KIND_LOAD)
			mem[{pixel_y[YB-1:0], pixel_x[XB-1:0]}] <= pixel_color;
		rd_q <= mem[{py_q, px_q}];
	end

	always_comb begin
		div_start = (st_q == ST_DIVS);
		// add half the area to round to nearest
		div_num = sum_q[ch_q] + SB'(area_q >> 1);
	end

	awba_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(area_q), .done(div_done), .quo(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			out_valid <= 1'b0;
			empty_area <= 1'b0;
			ch_q <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid && in_ready && kind == KIND_QUERY) begin
						if (rect_w <= 0 || rect_h < 0) begin
							empty_area <= 1'b1;
							res_q[0] <= BLACK; res_q[1] <= BLACK; res_q[2] <= BLACK;
							out_valid <= 1'b1;
						end else begin
							x0_q <= (rect_x < 0) ? '0 : PB'(rect_x);
							y0_q <= (rect_y < 0) ? '0 : PB'(rect_y);
							x1_q <= PB'(rect_x) + PB'(rect_w);
							y1_q <= PB'(rect_y) + PB'(rect_h);
							st_q <= ST_CLIP;
						end
					end
				end
				ST_CLIP: begin
					x1_q <= (xe < wlim) ? xe : wlim;
					y1_q <= (ye < hlim) ? ye : hlim;
					st_q <= ST_AREA;
				end
				ST_AREA: begin
					if (x1_q <= x0_q || y1_q <= y0_q) begin
						empty_area <= 1'b1;
						res_q[0] <= BLACK; res_q[1] <= BLACK; res_q[2] <= BLACK;
						out_valid <= 1'b1;
						st_q <= ST_IDLE;
					end else begin
						area_q <= ARB'(ax[CB-1:0]) * ARB'(ay[CB-1:0]);
						px_q <= rxe[FRAC_BITS +: XB];
						pxs_q <= rxe[FRAC_BITS +: XB];
						py_q <= rye[FRAC_BITS +: YB];
						sum_q[0] <= '0; sum_q[1] <= '0; sum_q[2] <= '0;
						st_q <= ST_RD;
					end
				end
				ST_RD: begin
					wx_q <= WB'(((xe < pxh) ? xe : pxh) - ((rxe > pxl) ? rxe : pxl));
					wy_q <= WB'(((ye < pyh) ? ye : pyh) - ((rye > pyl) ? rye : pyl));
					st_q <= ST_MUL;
				end
				ST_MUL: begin
					wt_q <= wx_q * wy_q;
					st_q <= ST_ACC;
				end
				ST_ACC: begin
					sum_q[0] <= sum_q[0] + SB'(PRB'(wt_q) * PRB'(rd_q[23:16]));
					sum_q[1] <= sum_q[1] + SB'(PRB'(wt_q) * PRB'(rd_q[15:8]));
					sum_q[2] <= sum_q[2] + SB'(PRB'(wt_q) * PRB'(rd_q[7:0]));
					st_q <= ST_RD;
					if (pxh < xe) begin
						px_q <= px_q + 1'b1;
					end else begin
						px_q <= pxs_q;
						if (pyh < ye) py_q <= py_q + 1'b1;
						else begin
							ch_q <= '0;
							st_q <= ST_DIVS;
						end
					end
				end
				ST_DIVS: begin
					st_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (div_done) begin
						res_q[ch_q] <= div_quo;
						if (ch_q == 2'd2) st_q <= ST_OUT;
						else begin
							ch_q <= ch_q + 1'b1;
							st_q <= ST_DIVS;
						end
					end
				end
				ST_OUT: begin
					empty_area <= 1'b0;
					out_valid <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign avg_red = res_q[0];
	assign avg_green = res_q[1];
	assign avg_blue = res_q[2];
endmodule
`default_nettype wire

[design/awba_checker.sv]
// Port checker for the box average block
`timescale 1ns / 1ps
`default_nettype none
`include "area_weighted_box_average_assert.svh"
module awba_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic empty_area,
	input wire logic [7:0] avg_red,
	input wire logic [7:0] avg_green,
	input wire logic [7:0] avg_blue
)
;
	`AWBA_ASSERT_IMP(a_no_in_while_out, out_valid, !in_ready)
	`AWBA_ASSERT_IMP(a_empty_black, out_valid && empty_area,
		avg_red == 8'd0 && avg_green == 8'd0 && avg_blue == 8'd0)
	`AWBA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
	`AWBA_ASSERT_NXT(a_out_stable, out_valid && !out_ready,
		$stable({avg_red, avg_green, avg_blue, empty_area}))
endmodule
bind area_weighted_box_average awba_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .empty_area(empty_area),
	.avg_red(avg_red), .avg_green(avg_green), .avg_blue(avg_blue)
);
`default_nettype wire

[dv/area_weighted_box_average_tb.sv]
// Testbench for the box average block: random loads and queries against a scoreboard
`timescale 1ns / 1ps
`default_nettype none
module area_weighted_box_average_tb;
	import awba_pkg::*;

	typedef struct {
		logic                kind;
		logic [5:0]          px;
		logic [5:0]          py;
		logic [23:0]         color;
		logic signed [14:0]  rx;
		logic signed [14:0]  ry;
		logic signed [14:0]  rw;
		logic signed [14:0]  rh;
	} txn_t;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       empty;
	} avg_t;

	class box_scoreboard;
		logic [23:0] image [MAX_WIDTH*MAX_HEIGHT];
		logic [6:0]  img_w = 7'd64;
		logic [6:0]  img_h = 7'd64;
		avg_t        avg_q[$];
		int          errors = 0;

		function void set_dim(logic idx, logic [6:0] v);
			if (idx == CFG_WIDTH) img_w = v;
			else img_h = v;
		endfunction

		task report(string what, int got, int want);
			errors++;
			$display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
		endtask

		function void note_input(txn_t t);
			longint one, x0, y0, x1, y1, w, h, area, wx, wy, v;
			longint acc[3];
			logic [23:0] c;
			avg_t a;
			one = 1 << FRAC_BITS;
			if (t.kind == KIND_LOAD) begin
				image[t.py * MAX_WIDTH + t.px] = t.color;
				return;
			end
			a = '{BLACK, BLACK, BLACK, 1'b1};
			w = (img_w > MAX_WIDTH) ? MAX_WIDTH : img_w;
			h = (img_h > MAX_HEIGHT) ? MAX_HEIGHT : img_h;
			x0 = t.rx; y0 = t.ry;
			x1 = x0 + longint'(t.rw);
			y1 = y0 + longint'(t.rh);
			if (x0 < 0) x0 = 0;
			if (y0 < 0) y0 = 0;
			if (x1 > w * one) x1 = w * one;
			if (y1 > h * one) y1 = h * one;
			if (t.rw > 0 && t.rh >= 0 && x1 > x0 && y1 > y0) begin
				area = (x1 - x0) * (y1 - y0);
				acc = '{0, 0, 0};
				for (longint py = y0 / one; py * one < y1; py++) begin
					wy = (y1 < (py + 1) * one ? y1 : (py + 1) * one)
						- (y0 > py * one ? y0 : py * one);
					for (longint px = x0 / one; px * one < x1; px++) begin
						wx = (x1 < (px + 1) * one ? x1 : (px + 1) * one)
							- (x0 > px * one ? x0 : px * one);
						c = image[py * MAX_WIDTH + px];
						acc[0] += wx * wy * c[23:16];
						acc[1] += wx * wy * c[15:8];
						acc[2] += wx * wy * c[7:0];
					end
				end
				for (int k = 0; k < 3; k++) begin
					v = (acc[k] + area / 2) / area;
					acc[k] = v > 255 ? 255 : v;
				end
				a = '{acc[0][7:0], acc[1][7:0], acc[2][7:0], 1'b0};
			end
			avg_q.push_back(a);
		endfunction

		task check_result(avg_t r);
			avg_t e;
			if (avg_q.size() == 0) begin
				report("unexpected transaction", 0, 0);
				return;
			end
			e = avg_q.pop_front();
			if (r.red !== e.red) report("avg_red", r.red, e.red);
			if (r.green !== e.green) report("avg_green", r.green, e.green);
			if (r.blue !== e.blue) report("avg_blue", r.blue, e.blue);
			if (r.empty !== e.empty) report("empty_area", r.empty, e.empty);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_ready;
	logic kind = 0;
	logic [5:0] pixel_x = 0, pixel_y = 0;
	logic [23:0] pixel_color = 0;
	logic signed [14:0] rect_x = 0, rect_y = 0, rect_w = 0, rect_h = 0;
	logic out_valid, out_ready = 0;
	logic [7:0] avg_red, avg_green, avg_blue;
	logic empty_area;
	logic cfg_we = 0, cfg_index = 0;
	logic [6:0] cfg_data = 0;

	box_scoreboard sb = new();
	bit quiet = 0;
	bit squeeze_done = 0;
	int results_seen = 0;

	always #5 clk = ~clk;

	area_weighted_box_average u_top (.*);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_result('{avg_red, avg_green, avg_blue, empty_area});
			results_seen++;
		end
	end

	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				out_ready <= 0;
			end else if (!squeeze_done && results_seen >= 100) begin
				out_ready <= 0;
				repeat (3000) @(negedge clk);
				squeeze_done = 1;
				out_ready <= 1;
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				n = $urandom_range(1, 14);
				out_ready <= 0;
				repeat (n) @(negedge clk);
				out_ready <= 1;
			end else begin
				out_ready <= 1;
			end
		end
	end

	task automatic send(txn_t t);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			in_valid <= 0;
			repeat ($urandom_range(1, 14) - 1) @(negedge clk);
		end
		@(negedge clk);
		kind <= t.kind;
		pixel_x <= t.px;
		pixel_y <= t.py;
		pixel_color <= t.color;
		rect_x <= t.rx;
		rect_y <= t.ry;
		rect_w <= t.rw;
		rect_h <= t.rh;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(t);
	endtask

	task automatic load(int x, int y, logic [23:0] c);
		txn_t t;
		t = '{KIND_LOAD, x[5:0], y[5:0], c, 15'($urandom), 15'($urandom),
			15'($urandom), 15'($urandom)};
		send(t);
	endtask

	task automatic query(int x, int y, int w, int h);
		txn_t t;
		t = '{KIND_QUERY, 6'($urandom), 6'($urandom), 24'($urandom),
			x[14:0], y[14:0], w[14:0], h[14:0]};
		send(t);
	endtask

	task automatic set_image(logic [6:0] w, logic [6:0] h);
		@(negedge clk);
		in_valid <= 0;
		wait (sb.avg_q.size() == 0);
		repeat (20) @(negedge clk);
		cfg_we <= 1;
		cfg_index <= CFG_WIDTH;
		cfg_data <= w;
		@(negedge clk);
		cfg_index <= CFG_HEIGHT;
		cfg_data <= h;
		@(negedge clk);
		cfg_we <= 0;
		sb.set_dim(CFG_WIDTH, w);
		sb.set_dim(CFG_HEIGHT, h);
	endtask

	task automatic random_phase(int count);
		int r, ew, eh;
		ew = (sb.img_w > MAX_WIDTH) ? MAX_WIDTH : sb.img_w;
		eh = (sb.img_h > MAX_HEIGHT) ? MAX_HEIGHT : sb.img_h;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				load($urandom_range(0, 63), $urandom_range(0, 63), 24'($urandom));
			end else if (r < 43) begin
				query($signed(15'($urandom)), $signed(15'($urandom)),
					$signed(15'($urandom)), $signed(15'($urandom)));
			end else if (r < 45) begin
				query($urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
					$urandom_range(0, ew * 256 + 600), $urandom_range(0, eh * 256 + 600));
			end else begin
				query($urandom_range(0, ew * 256 + 384) - 256,
					$urandom_range(0, eh * 256 + 384) - 256,
					$urandom_range(0, 1088) - 64, $urandom_range(0, 1088) - 64);
			end
		end
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1;
		for (int y = 0; y < 24; y++)
			for (int x = 0; x < 24; x++)
				load(x, y, 24'($urandom));
		for (int x = 24; x < MAX_WIDTH; x++)
			load(x, 0, 24'($urandom));
		for (int y = 24; y < MAX_HEIGHT; y++)
			load(0, y, 24'($urandom));
		load(0, 0, 24'hFFFFFF);
		load(63, 63, 24'h000000);
		load(1, 0, 24'hFF00FF);
		set_image(7'd24, 7'd24);
		query(0, 0, 256, 256);
		query(16128, 16128, 256, 256);
		query(0, 0, 0, 256);
		query(0, 0, -16384, 256);
		query(0, 0, 256, -1);
		query(0, 0, 256, 0);
		query(16383, 0, 256, 256);
		query(-16384, -16384, 16383, 16383);
		query(-128, -128, 512, 512);
		query(64, 64, 320, 200);
		query(0, 0, 16383, 16383);
		query(128, 0, 128, 128);
		query(16000, 16000, 16383, 16383);
		random_phase(200);
		set_image(7'd1, 7'd1);
		query(0, 0, 16383, 16383);
		query(128, 128, 64, 64);
		random_phase(150);
		set_image(7'd64, 7'd1);
		random_phase(150);
		set_image(7'd1, 7'd64);
		random_phase(150);
		set_image(7'd0, 7'd127);
		query(0, 0, 512, 512);
		random_phase(50);
		set_image(7'd127, 7'd0);
		random_phase(50);
		set_image(7'd127, 7'd1);
		random_phase(100);
		set_image(7'd1, 7'd127);
		random_phase(100);
		set_image(7'($urandom_range(2, 23)), 7'($urandom_range(2, 23)));
		random_phase(100);
		set_image(7'd24, 7'd24);
		quiet = 1;
		random_phase(150);
		@(negedge clk);
		in_valid <= 0;
		wait (sb.avg_q.size() == 0);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.avg_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#200ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire

[area_weighted_box_average.f]
+incdir+design
design/awba_pkg.sv
design/awba_div.sv
design/area_weighted_box_average.sv
design/awba_checker.sv
dv/area_weighted_box_average_tb.sv
